// ----- design/cld_pkg.sv -----
// cld_pkg: shared types, constants and the microcode program of the character-LCD
// write sequencer. Used by char_lcd_write_sequencer, cld_bcd_conv and cld_port_checker.
package cld_pkg;

  // Defaults and fixed sizes
  localparam int LINE_LENGTH_DEF = 16;
  localparam int MAX_WRITES      = 12;
  localparam int GEN_W           = $clog2(MAX_WRITES + 1);
  localparam int NUM_W           = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int DIG_W           = $clog2(BCD_DIGITS + 1);
  localparam int PC_W            = 5;

  // Request codes
  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_COMMAND = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_GOTO    = 3'd3;
  localparam logic [2:0] ACT_GLYPH   = 3'd4;
  localparam logic [2:0] ACT_NUMBER  = 3'd5;

  // Bus bytes
  localparam logic [7:0] LCD_FUNC_SET = 8'b0011_1000;
  localparam logic [7:0] LCD_DISP_ON  = 8'b0000_1100;
  localparam logic [7:0] LCD_CLEAR    = 8'b0000_0001;
  localparam logic [7:0] CURSOR_HOME  = 8'h80;
  localparam logic [7:0] CURSOR_ROW1  = 8'hC0;
  localparam logic [3:0] ASCII_DIGIT  = 4'h3;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic        row;
    logic [5:0]  column;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
    logic [31:0] number;
  } in_word_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  // Micro-operations
  typedef enum logic [2:0] {
    UOP_CMD,    // command write from src
    UOP_DATA,   // data write from src, count one character
    UOP_WRAP,   // cursor move if the character count hit a line boundary
    UOP_LOOP,   // next glyph row, jump to target until all eight are sent
    UOP_CONV,   // run binary-to-BCD conversion, wait for it
    UOP_DSKIP,  // drop leading zero digits; jump to target if value is zero
    UOP_DNEXT,  // next digit, jump to target while digits remain
    UOP_END     // request done, flag last write
  } uop_t;

  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_FUNC_SET,
    SRC_DISP_ON,
    SRC_CLEAR,
    SRC_BVAL,
    SRC_GOTO,
    SRC_CGADDR,
    SRC_GROW,
    SRC_SLOT,
    SRC_DIGIT
  } src_t;

  typedef struct packed {
    uop_t            op;
    src_t            src;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Program entry points
  localparam logic [PC_W-1:0] PC_INIT      = 5'd0;
  localparam logic [PC_W-1:0] PC_IDLE      = 5'd3;
  localparam logic [PC_W-1:0] PC_COMMAND   = 5'd4;
  localparam logic [PC_W-1:0] PC_DATA      = 5'd6;
  localparam logic [PC_W-1:0] PC_GOTO      = 5'd9;
  localparam logic [PC_W-1:0] PC_GLYPH     = 5'd11;
  localparam logic [PC_W-1:0] PC_GLYPH_ROW = 5'd12;
  localparam logic [PC_W-1:0] PC_NUMBER    = 5'd19;
  localparam logic [PC_W-1:0] PC_DIGIT     = 5'd21;
  localparam logic [PC_W-1:0] PC_NUM_END   = 5'd24;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{op: UOP_END, src: SRC_NONE, target: PC_IDLE};
    case (pc)
      // init
      5'd0:  cw = '{op: UOP_CMD,   src: SRC_FUNC_SET, target: PC_IDLE};
      5'd1:  cw = '{op: UOP_CMD,   src: SRC_DISP_ON,  target: PC_IDLE};
      5'd2:  cw = '{op: UOP_CMD,   src: SRC_CLEAR,    target: PC_IDLE};
      5'd3:  cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      // raw command
      5'd4:  cw = '{op: UOP_CMD,   src: SRC_BVAL,     target: PC_IDLE};
      5'd5:  cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      // character
      5'd6:  cw = '{op: UOP_DATA,  src: SRC_BVAL,     target: PC_IDLE};
      5'd7:  cw = '{op: UOP_WRAP,  src: SRC_NONE,     target: PC_IDLE};
      5'd8:  cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      // goto
      5'd9:  cw = '{op: UOP_CMD,   src: SRC_GOTO,     target: PC_IDLE};
      5'd10: cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      // glyph
      5'd11: cw = '{op: UOP_CMD,   src: SRC_CGADDR,   target: PC_IDLE};
      5'd12: cw = '{op: UOP_DATA,  src: SRC_GROW,     target: PC_IDLE};
      5'd13: cw = '{op: UOP_WRAP,  src: SRC_NONE,     target: PC_IDLE};
      5'd14: cw = '{op: UOP_LOOP,  src: SRC_NONE,     target: PC_GLYPH_ROW};
      5'd15: cw = '{op: UOP_CMD,   src: SRC_GOTO,     target: PC_IDLE};
      5'd16: cw = '{op: UOP_DATA,  src: SRC_SLOT,     target: PC_IDLE};
      5'd17: cw = '{op: UOP_WRAP,  src: SRC_NONE,     target: PC_IDLE};
      5'd18: cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      // decimal number
      5'd19: cw = '{op: UOP_CONV,  src: SRC_NONE,     target: PC_IDLE};
      5'd20: cw = '{op: UOP_DSKIP, src: SRC_NONE,     target: PC_NUM_END};
      5'd21: cw = '{op: UOP_DATA,  src: SRC_DIGIT,    target: PC_IDLE};
      5'd22: cw = '{op: UOP_WRAP,  src: SRC_NONE,     target: PC_IDLE};
      5'd23: cw = '{op: UOP_DNEXT, src: SRC_NONE,     target: PC_DIGIT};
      5'd24: cw = '{op: UOP_END,   src: SRC_NONE,     target: PC_IDLE};
      default: cw = '{op: UOP_END, src: SRC_NONE,     target: PC_IDLE};
    endcase
    return cw;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] action);
    logic [PC_W-1:0] pc;
    case (action)
      ACT_INIT:    pc = PC_INIT;
      ACT_COMMAND: pc = PC_COMMAND;
      ACT_DATA:    pc = PC_DATA;
      ACT_GOTO:    pc = PC_GOTO;
      ACT_GLYPH:   pc = PC_GLYPH;
      ACT_NUMBER:  pc = PC_NUMBER;
      default:     pc = PC_IDLE;
    endcase
    return pc;
  endfunction

endpackage

// ----- design/char_lcd_write_sequencer.sv -----
// char_lcd_write_sequencer: top level, microcoded request sequencer for a character LCD.
// Depends on cld_pkg (types, microcode program) and cld_bcd_conv.
//
// Takes one request word at a time and turns it into a burst of LCD bus words
// (register select plus byte), the final word of each burst flagged with last.
// A microcode sequencer runs one program step per cycle while the output does not
// stall. A number first waits for the bit-serial BCD conversion, then drops the
// leading zero digits and prints the remaining ones. A new request is taken in
// the cycle after the previous one ends; the last word may still be waiting in
// the output register then. Requests 6 and 7 and the number zero give no bus
// words. Bursts are capped at 12 words; the character count still advances for
// writes past the cap.
module char_lcd_write_sequencer #(
  parameter int LINE_LENGTH = cld_pkg::LINE_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cld_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cld_pkg::out_word_t  out_word
);

  // Counter compare points, 7 bits so that a double line length beyond the
  // 6-bit count range never matches.
  localparam logic [6:0] ROW1_AT = 7'(LINE_LENGTH);
  localparam logic [6:0] HOME_AT = 7'(2 * LINE_LENGTH);

  // Sequencer state
  logic                          busy_r;
  logic [cld_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [5:0]                    char_cnt_r, char_cnt_nxt;
  logic [2:0]                    loop_r, loop_nxt;
  logic [cld_pkg::GEN_W-1:0]     gen_cnt_r;
  logic                          pend_valid_r;
  logic                          out_valid_r;

  // Payload
  cld_pkg::in_word_t             req_r;
  logic [63:0]                   glyph_r, glyph_nxt;
  logic [cld_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [cld_pkg::DIG_W-1:0]     dig_left_r, dig_left_nxt;
  cld_pkg::out_word_t            pend_r;
  cld_pkg::out_word_t            out_r;

  cld_pkg::ctrl_word_t           cw;
  cld_pkg::conv_status_t         conv_st;
  logic [cld_pkg::BCD_W-1:0]     conv_bcd;
  logic                          conv_start;

  logic [7:0] src_byte;
  logic       emit, emit_rs, finish;
  logic [7:0] emit_byte;
  logic       keep, need_slot, slot_ok, go, load_out, in_accept;
  logic [3:0] top_digit;

  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  assign cw        = cld_pkg::ucode_rom(pc_r);
  assign top_digit = bcd_r[cld_pkg::BCD_W-1 -: 4];

  // Byte source select
  always_comb begin
    case (cw.src)
      cld_pkg::SRC_FUNC_SET: src_byte = cld_pkg::LCD_FUNC_SET;
      cld_pkg::SRC_DISP_ON:  src_byte = cld_pkg::LCD_DISP_ON;
      cld_pkg::SRC_CLEAR:    src_byte = cld_pkg::LCD_CLEAR;
      cld_pkg::SRC_BVAL:     src_byte = req_r.byte_value;
      cld_pkg::SRC_GOTO:     src_byte = {1'b1, req_r.row, req_r.column};
      cld_pkg::SRC_CGADDR:   src_byte = {2'b01, req_r.glyph_slot, 3'b000};
      cld_pkg::SRC_GROW:     src_byte = glyph_r[7:0];
      cld_pkg::SRC_SLOT:     src_byte = {5'b00000, req_r.glyph_slot};
      cld_pkg::SRC_DIGIT:    src_byte = {cld_pkg::ASCII_DIGIT, top_digit};
      default:               src_byte = 8'h00;
    endcase
  end

  // Step decode
  always_comb begin
    emit         = 1'b0;
    emit_rs      = 1'b0;
    emit_byte    = src_byte;
    finish       = 1'b0;
    conv_start   = 1'b0;
    pc_nxt       = pc_r + 1'b1;
    char_cnt_nxt = char_cnt_r;
    loop_nxt     = loop_r;
    glyph_nxt    = glyph_r;
    bcd_nxt      = bcd_r;
    dig_left_nxt = dig_left_r;
    case (cw.op)
      cld_pkg::UOP_CMD: begin
        emit = 1'b1;
      end
      cld_pkg::UOP_DATA: begin
        emit         = 1'b1;
        emit_rs      = 1'b1;
        char_cnt_nxt = char_cnt_r + 1'b1;
      end
      cld_pkg::UOP_WRAP: begin
        if ({1'b0, char_cnt_r} == ROW1_AT) begin
          emit      = 1'b1;
          emit_byte = cld_pkg::CURSOR_ROW1;
        end else if ({1'b0, char_cnt_r} == HOME_AT) begin
          emit         = 1'b1;
          emit_byte    = cld_pkg::CURSOR_HOME;
          char_cnt_nxt = '0;
        end
      end
      cld_pkg::UOP_LOOP: begin
        if (loop_r != 3'd7) begin
          loop_nxt  = loop_r + 1'b1;
          glyph_nxt = glyph_r >> 8;
          pc_nxt    = cw.target;
        end
      end
      cld_pkg::UOP_CONV: begin
        conv_start = busy_r && !conv_st.busy && !conv_st.done;
        if (conv_st.done) begin
          bcd_nxt      = conv_bcd;
          dig_left_nxt = cld_pkg::DIG_W'(cld_pkg::BCD_DIGITS);
        end else begin
          pc_nxt = pc_r;
        end
      end
      cld_pkg::UOP_DSKIP: begin
        if (bcd_r == '0) begin
          pc_nxt = cw.target;
        end else if (top_digit == 4'd0) begin
          bcd_nxt      = bcd_r << 4;
          dig_left_nxt = dig_left_r - 1'b1;
          pc_nxt       = pc_r;
        end
      end
      cld_pkg::UOP_DNEXT: begin
        bcd_nxt      = bcd_r << 4;
        dig_left_nxt = dig_left_r - 1'b1;
        if (dig_left_r != cld_pkg::DIG_W'(1)) begin
          pc_nxt = cw.target;
        end
      end
      cld_pkg::UOP_END: begin
        finish = 1'b1;
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  // One word is held back in pend so that the final one can be flagged last.
  assign keep      = emit && (gen_cnt_r < cld_pkg::GEN_W'(cld_pkg::MAX_WRITES));
  assign slot_ok   = !out_valid_r || !out_stall;
  assign need_slot = pend_valid_r && (keep || finish);
  assign go        = busy_r && (!need_slot || slot_ok);
  assign load_out  = go && need_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= cld_pkg::PC_IDLE;
      char_cnt_r   <= '0;
      loop_r       <= '0;
      gen_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        busy_r       <= 1'b1;
        pc_r         <= cld_pkg::entry_pc(in_word.action);
        loop_r       <= '0;
        gen_cnt_r    <= '0;
        pend_valid_r <= 1'b0;
      end else if (go) begin
        pc_r       <= pc_nxt;
        char_cnt_r <= char_cnt_nxt;
        loop_r     <= loop_nxt;
        if (keep) begin
          pend_valid_r <= 1'b1;
          gen_cnt_r    <= gen_cnt_r + 1'b1;
        end
        if (finish) begin
          busy_r       <= 1'b0;
          pend_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r   <= in_word;
      glyph_r <= in_word.glyph_rows;
    end else if (go) begin
      glyph_r    <= glyph_nxt;
      bcd_r      <= bcd_nxt;
      dig_left_r <= dig_left_nxt;
      if (keep) begin
        pend_r.is_data  <= emit_rs;
        pend_r.lcd_byte <= emit_byte;
        pend_r.last     <= 1'b0;
      end
    end
    if (load_out) begin
      out_r.is_data  <= pend_r.is_data;
      out_r.lcd_byte <= pend_r.lcd_byte;
      out_r.last     <= finish;
    end
  end

  cld_bcd_conv u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .value  (req_r.number),
    .status (conv_st),
    .bcd    (conv_bcd)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

// ----- design/cld_bcd_conv.sv -----
// cld_bcd_conv: bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on cld_pkg.
module cld_bcd_conv (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [cld_pkg::NUM_W-1:0] value,
  output cld_pkg::conv_status_t    status,
  output logic [cld_pkg::BCD_W-1:0] bcd
);

  localparam int CNT_W = $clog2(cld_pkg::NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cld_pkg::NUM_W - 1);

  logic                       busy_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [cld_pkg::NUM_W-1:0]  bin_r;
  logic [cld_pkg::BCD_W-1:0]  bcd_r;
  logic [cld_pkg::BCD_W-1:0]  adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < cld_pkg::BCD_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= value;
      bcd_r <= '0;
    end else if (busy_r) begin
      bcd_r <= {adj[cld_pkg::BCD_W-2:0], bin_r[cld_pkg::NUM_W-1]};
      bin_r <= {bin_r[cld_pkg::NUM_W-2:0], 1'b0};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign bcd         = bcd_r;

endmodule

// ----- design/cld_port_checker.sv -----
// cld_port_checker: port-level assertions for char_lcd_write_sequencer, bound to the top.
// Depends on cld_pkg.
module cld_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cld_pkg::out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset leaves the block ready for a request
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind char_lcd_write_sequencer cld_port_checker u_port_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ----- tb/testbench.sv -----
// testbench: self-checking bench for char_lcd_write_sequencer with a built-in predictor.
// Depends on cld_pkg for the request/bus word types, request codes and bus bytes.
`timescale 1ns / 100ps

module testbench;
  import cld_pkg::*;

  localparam int LINE_LEN    = LINE_LENGTH_DEF;
  localparam int RAND_WORDS  = 410;
  localparam int LONG_HOLD   = 300;    // receiver hold-off, long enough to back up the input
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 400000;

  // Request codes the block does not know; they must leave no trace
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  // CGRAM address command base
  localparam logic [7:0] CGRAM_BASE = 8'h40;
  localparam out_word_t  NO_WORD    = '0;

  // One directed row: the request plus, where obvious, the hand-written bus words
  typedef struct packed {
    in_word_t      req;
    logic          by_hand;
    logic [1:0]    n_typed;
    out_word_t [2:0] typed;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  char_lcd_write_sequencer #(.LINE_LENGTH(LINE_LEN)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Predictor state: 6-bit character counter, same as the block's
  logic [5:0] char_tally;
  out_word_t  lcd_writes_q[$];      // burst for the request being predicted
  out_word_t  pending_writes_q[$];  // bus words still owed by the block
  stim_row_t  directed_rows[$];
  int         errors = 0;
  int         cycles = 0;
  bit         no_idle;              // both sides run flat out
  bit         rx_hold_long;         // receiver takes its long stall once
  out_word_t  want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_word_t req(input logic [2:0] act, input logic [7:0] bval,
                                   input logic r, input logic [5:0] col,
                                   input logic [2:0] slot, input logic [63:0] rows,
                                   input logic [31:0] num);
    in_word_t w;
    w.action     = act;
    w.byte_value = bval;
    w.row        = r;
    w.column     = col;
    w.glyph_slot = slot;
    w.glyph_rows = rows;
    w.number     = num;
    return w;
  endfunction

  function automatic out_word_t wr(input logic rs, input logic [7:0] b, input logic lst);
    out_word_t o;
    o.is_data  = rs;
    o.lcd_byte = b;
    o.last     = lst;
    return o;
  endfunction

  function automatic void add_row(input in_word_t w, input logic by_hand, input int n,
                                  input out_word_t t0, input out_word_t t1,
                                  input out_word_t t2);
    stim_row_t r;
    r.req      = w;
    r.by_hand  = by_hand;
    r.n_typed  = 2'(n);
    r.typed[0] = t0;
    r.typed[1] = t1;
    r.typed[2] = t2;
    directed_rows.push_back(r);
  endfunction

  // Burst is capped at MAX_WRITES; writes past the cap are dropped
  function automatic void emit(input logic rs, input logic [7:0] b);
    if (lcd_writes_q.size() < MAX_WRITES)
      lcd_writes_q.push_back(wr(rs, b, 1'b0));
  endfunction

  function automatic logic [7:0] cursor_addr(input logic r, input logic [5:0] col);
    return CURSOR_HOME | {1'b0, r, col};
  endfunction

  // Every data write bumps the counter; line 1 move at LINE_LEN, home at twice that
  function automatic void put_char(input logic [7:0] b);
    emit(1'b1, b);
    char_tally = char_tally + 6'd1;
    if (int'(char_tally) == LINE_LEN)
      emit(1'b0, CURSOR_ROW1);
    if (int'(char_tally) == 2 * LINE_LEN) begin
      emit(1'b0, CURSOR_HOME);
      char_tally = '0;
    end
  endfunction

  function automatic void predict_lcd_writes(input in_word_t w);
    logic [31:0] v;
    logic [3:0]  dig [10];
    int          nd;
    out_word_t   tail;
    lcd_writes_q.delete();
    case (w.action)
      ACT_INIT: begin
        emit(1'b0, LCD_FUNC_SET);
        emit(1'b0, LCD_DISP_ON);
        emit(1'b0, LCD_CLEAR);
      end
      ACT_COMMAND: emit(1'b0, w.byte_value);
      ACT_DATA:    put_char(w.byte_value);
      ACT_GOTO:    emit(1'b0, cursor_addr(w.row, w.column));
      ACT_GLYPH: begin
        emit(1'b0, CGRAM_BASE | {2'b00, w.glyph_slot, 3'b000});
        for (int i = 0; i < 8; i++)
          put_char(w.glyph_rows[8*i +: 8]);
        emit(1'b0, cursor_addr(w.row, w.column));
        put_char({5'b0, w.glyph_slot});
      end
      ACT_NUMBER: begin
        // zero prints nothing at all
        v  = w.number;
        nd = 0;
        while (v != 0) begin
          dig[nd] = 4'(v % 10);
          v       = v / 10;
          nd++;
        end
        for (int i = nd - 1; i >= 0; i--)
          put_char({ASCII_DIGIT, dig[i]});
      end
      default: ;
    endcase
    if (lcd_writes_q.size() > 0) begin
      tail      = lcd_writes_q.pop_back();
      tail.last = 1'b1;
      lcd_writes_q.push_back(tail);
    end
  endfunction

  // Offer one request word; predict once it is taken.
  // valid stays high between back-to-back words (never dropped and raised in one step)
  task automatic send_row(input stim_row_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= r.req;
    do @(posedge clk); while (in_stall);
    predict_lcd_writes(r.req);
    if (r.by_hand) begin
      for (int i = 0; i < int'(r.n_typed); i++)
        pending_writes_q.push_back(r.typed[i]);
    end else begin
      foreach (lcd_writes_q[i])
        pending_writes_q.push_back(lcd_writes_q[i]);
    end
  endtask

  // Sender goes quiet until the block has paid out every owed word
  task automatic drain_outputs;
    in_valid <= 1'b0;
    wait (pending_writes_q.size() == 0);
    @(posedge clk);
  endtask

  function automatic in_word_t random_req();
    in_word_t w;
    int       pick;
    w = req(3'(0), 8'($urandom), 1'($urandom), 6'($urandom), 3'($urandom),
            {$urandom, $urandom}, $urandom >> $urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if      (pick < 4)  w.action = ACT_INIT;
    else if (pick < 12) w.action = ACT_COMMAND;
    else if (pick < 45) w.action = ACT_DATA;
    else if (pick < 55) w.action = ACT_GOTO;
    else if (pick < 70) w.action = ACT_GLYPH;
    else if (pick < 95) w.action = ACT_NUMBER;
    else                w.action = pick[0] ? ACT_SPARE7 : ACT_SPARE6;
    // pin the number extremes now and then
    if ($urandom_range(0, 19) == 0)
      w.number = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    return w;
  endfunction

  // Receiver: random stall before each word, one long hold-off on request
  initial begin : bus_sink
    int hold;
    bit long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_long && !long_done) begin
        hold      = LONG_HOLD;
        long_done = 1'b1;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Bus word checker: each taken word against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_writes_q.size() == 0) begin
        $error("unexpected bus word: is_data %0d lcd_byte %02h last %0d",
               out_word.is_data, out_word.lcd_byte, out_word.last);
        errors++;
      end else begin
        want = pending_writes_q.pop_front();
        if (out_word.is_data !== want.is_data) begin
          $error("is_data: expected %0d, actual %0d", want.is_data, out_word.is_data);
          errors++;
        end
        if (out_word.lcd_byte !== want.lcd_byte) begin
          $error("lcd_byte: expected %02h, actual %02h", want.lcd_byte, out_word.lcd_byte);
          errors++;
        end
        if (out_word.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_word.last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int        sent;
    no_idle      = 1'b0;
    rx_hold_long = 1'b0;
    char_tally   = '0;
    in_valid     = 1'b0;
    in_word      = '0;
    rst_n        = 1'b0;

    // Directed table; hand-written words only where they are obvious.
    // Counter starts at zero after reset.
    add_row(req(ACT_INIT, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b1, 3,
            wr(1'b0, LCD_FUNC_SET, 1'b0), wr(1'b0, LCD_DISP_ON, 1'b0),
            wr(1'b0, LCD_CLEAR, 1'b1));
    add_row(req(ACT_COMMAND, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b1, 1,
            wr(1'b0, 8'h00, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_COMMAND, 8'hFF, 1'b1, 6'd63, 3'd7, '1, '1), 1'b1, 1,
            wr(1'b0, 8'hFF, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_GOTO, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b1, 1,
            wr(1'b0, 8'h80, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_GOTO, 8'hFF, 1'b1, 6'd63, 3'd7, '1, '1), 1'b1, 1,
            wr(1'b0, 8'hFF, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_GOTO, 8'h00, 1'b0, 6'd63, 3'd0, 64'd0, 32'd0), 1'b1, 1,
            wr(1'b0, 8'hBF, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_DATA, 8'h41, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b1, 1,
            wr(1'b1, 8'h41, 1'b1), NO_WORD, NO_WORD);
    add_row(req(ACT_DATA, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_DATA, 8'hFF, 1'b1, 6'd63, 3'd7, '1, '1), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    // zero and unknown request codes produce no bus words
    add_row(req(ACT_NUMBER, 8'hFF, 1'b1, 6'd63, 3'd7, '1, 32'd0), 1'b1, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_SPARE6, 8'h55, 1'b1, 6'd21, 3'd5, '1, '1), 1'b1, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_SPARE7, 8'hAA, 1'b0, 6'd42, 3'd2, 64'd0, 32'd7), 1'b1, 0,
            NO_WORD, NO_WORD, NO_WORD);
    // ten digits, then small numbers that carry the counter over line 1
    add_row(req(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'hFFFF_FFFF), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd1), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd10), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_GLYPH, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_GLYPH, 8'hFF, 1'b1, 6'd63, 3'd7, '1, '1), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd1000000000), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_GLYPH, 8'h00, 1'b1, 6'd5, 3'd3, 64'h0102_0408_1020_4080, 32'd0),
            1'b0, 0, NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_NUMBER, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd9876543), 1'b0, 0,
            NO_WORD, NO_WORD, NO_WORD);
    add_row(req(ACT_INIT, 8'h00, 1'b0, 6'd0, 3'd0, 64'd0, 32'd0), 1'b1, 3,
            wr(1'b0, LCD_FUNC_SET, 1'b0), wr(1'b0, LCD_DISP_ON, 1'b0),
            wr(1'b0, LCD_CLEAR, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_row(directed_rows[i]);
    drain_outputs();

    // Random part
    sent = 0;
    while (sent < RAND_WORDS) begin
      no_idle = (sent >= 120 && sent < 160) || (sent >= 240 && sent < 290);
      if (sent == 250)
        rx_hold_long = 1'b1;    // block backs up while the sender keeps pushing
      if (sent == 350)
        drain_outputs();
      r.req     = random_req();
      r.by_hand = 1'b0;
      r.n_typed = '0;
      r.typed   = '0;
      send_row(r);
      sent++;
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    wait (pending_writes_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
